### sv/v4cidr_pkg.sv
// ============================================================================
// v4cidr_pkg
// Shared widths, character codes, error codes and word types for the
// IPv4 CIDR text parser.
// ============================================================================
`default_nettype none

package v4cidr_pkg;

    localparam int CHAR_W      = 8;
    localparam int ADDR_W      = 32;
    localparam int MASK_W      = 8;
    localparam int ERR_W       = 3;
    localparam int VAL_W       = 9;
    localparam int CNT_W       = 3;
    localparam int OCTETS      = 4;
    localparam int OCTET_BITS  = 8;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 48;

    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [MASK_W-1:0] DEFAULT_MASK = 8'd32;
    localparam logic [VAL_W-1:0]  VALUE_CAP    = 9'd256;
    localparam logic [VAL_W-1:0]  MAX_OCTET    = 9'd255;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE   = 3'd0,
        ERR_NUMBER = 3'd1,
        ERR_RANGE  = 3'd2,
        ERR_DOT    = 3'd3,
        ERR_SLASH  = 3'd4
    } err_t;

    typedef enum logic [1:0] {
        PH_OCTETS = 2'b01,
        PH_MASK   = 2'b10
    } phase_t;

    typedef struct packed {
        logic              last;
        logic [CHAR_W-1:0] ch;
    } item_t;

    typedef struct packed {
        err_t              error_code;
        logic [MASK_W-1:0] mask_length;
        logic [ADDR_W-1:0] address;
    } result_t;

endpackage

`default_nettype wire

### sv/ipv4_cidr_text_parser.sv
// A result word is registered: the input register feeds the parse logic,
// which loads the result register that drives m_*. Throughput: one character
// per cycle, sustained with m_tready held high.
// Reset: aresetn is synchronous, active low; it empties both registers and
// returns the parser to the start of a string.
// ============================================================================
// ipv4_cidr_text_parser
// Streams dotted-quad IPv4 text with an optional /mask and returns the
// address, mask length and first error for each string.
// ============================================================================
`default_nettype none

module ipv4_cidr_text_parser
    import v4cidr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [7:0] character
    input  wire logic                   s_tlast,   // last character of the string
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata    // [31:0] address, [39:32] mask_length,
                                                   // [42:40] error_code, [47:43] zero
);

    logic    take;
    logic    item_valid;
    item_t   item;
    logic    out_ready;
    logic    res_valid;
    result_t res;

    v4cidr_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    v4cidr_core u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .out_ready  (out_ready),
        .take       (take),
        .res_valid  (res_valid),
        .res        (res)
    );

    v4cidr_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .res_valid (res_valid),
        .res       (res),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

`default_nettype wire

### sv/v4cidr_in_reg.sv
// ============================================================================
// v4cidr_in_reg
// Input register for text characters; refills in the cycle it is drained.
// ============================================================================
`default_nettype none

module v4cidr_in_reg
    import v4cidr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_TDATA_W-1:0] s_tdata,   // [7:0] character
    input  wire logic                  s_tlast,   // last character of the string
    input  wire logic                  take,
    output logic                       item_valid,
    output item_t                      item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.ch   <= s_tdata[CHAR_W-1:0];
            item_reg.last <= s_tlast;
        end
    end

endmodule

`default_nettype wire

### sv/v4cidr_core.sv
// ============================================================================
// v4cidr_core
// Parser state and the per-character update; builds the result word on the
// last character and returns the state to its reset value.
// ============================================================================
`default_nettype none

module v4cidr_core
    import v4cidr_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic item_valid,
    input  item_t     item,
    input  wire logic out_ready,
    output logic      take,
    output logic      res_valid,
    output result_t   res
);

    typedef struct packed {
        phase_t            phase;
        logic [CNT_W-1:0]  cnt;
        logic [VAL_W-1:0]  rv;
        logic              ds;
        logic [ADDR_W-1:0] acc;
        err_t              err;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase: PH_OCTETS, cnt: '0, rv: '0, ds: 1'b0, acc: '0, err: ERR_NONE
    };

    // Ends the current octet: either flags an error or places the byte.
    function automatic state_t close_octet(input state_t s);
        state_t     r;
        logic [1:0] idx;
        r   = s;
        idx = s.cnt[1:0];
        if (!s.ds) begin
            r.err = ERR_NUMBER;
        end else if (s.rv > MAX_OCTET) begin
            r.err = ERR_RANGE;
        end else begin
            r.acc[idx*OCTET_BITS +: OCTET_BITS] =
                s.acc[idx*OCTET_BITS +: OCTET_BITS] | s.rv[OCTET_BITS-1:0];
            r.cnt = s.cnt + 3'd1;
            r.rv  = '0;
            r.ds  = 1'b0;
        end
        return r;
    endfunction

    state_t            st_reg;
    state_t            s1;
    state_t            s2;
    logic              is_digit;
    logic [3:0]        digit;
    logic [11:0]       prod;
    logic [MASK_W-1:0] mask;

    assign take      = item_valid && (!item.last || out_ready);
    assign res_valid = item_valid && item.last && out_ready;

    always_comb begin
        s1       = st_reg;
        digit    = item.ch[3:0];
        is_digit = (item.ch >= CHAR_ZERO) && (item.ch <= CHAR_NINE);
        prod     = ({3'b000, st_reg.rv} << 3) + ({3'b000, st_reg.rv} << 1)
                 + {8'h00, digit};

        if (st_reg.err == ERR_NONE) begin
            if (is_digit) begin
                s1.rv = (prod > {3'b000, VALUE_CAP}) ? VALUE_CAP : prod[VAL_W-1:0];
                s1.ds = 1'b1;
            end else if (st_reg.phase == PH_MASK) begin
                s1.err = ERR_NUMBER;
            end else begin
                s1 = close_octet(st_reg);
                if (s1.err == ERR_NONE) begin
                    if (s1.cnt < CNT_W'(OCTETS)) begin
                        if (item.ch != CHAR_DOT) s1.err = ERR_DOT;
                    end else if (item.ch != CHAR_SLASH) begin
                        s1.err = ERR_SLASH;
                    end else begin
                        s1.phase = PH_MASK;
                    end
                end
            end
        end

        // End-of-string checks; only the result uses them.
        s2   = s1;
        mask = '0;
        if (s1.err == ERR_NONE) begin
            if (s1.phase == PH_OCTETS) begin
                s2 = close_octet(s1);
                if (s2.err == ERR_NONE) begin
                    if (s2.cnt < CNT_W'(OCTETS)) s2.err = ERR_DOT;
                    else                         mask   = DEFAULT_MASK;
                end
            end else if (!s1.ds) begin
                s2.err = ERR_NUMBER;
            end else if (s1.rv > MAX_OCTET) begin
                s2.err = ERR_RANGE;
            end else begin
                mask = s1.rv[MASK_W-1:0];
            end
        end

        res.address     = s2.acc;
        res.mask_length = mask;
        res.error_code  = s2.err;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= STATE_RESET;
        end else if (take) begin
            st_reg <= item.last ? STATE_RESET : s1;
        end
    end

endmodule

`default_nettype wire

### sv/v4cidr_out_reg.sv
// ============================================================================
// v4cidr_out_reg
// Result register; takes a new word in the cycle the held one is read.
// ============================================================================
`default_nettype none

module v4cidr_out_reg
    import v4cidr_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   res_valid,
    input  result_t                     res,
    output logic                        out_ready,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata  // [31:0] address, [39:32] mask_length,
                                                 // [42:40] error_code, [47:43] zero
);

    logic    valid_reg;
    result_t res_reg;

    assign out_ready = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;
    assign m_tdata   = {(OUT_TDATA_W - $bits(result_t))'(0), res_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_ready) begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && out_ready) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire

### sv/v4cidr_checker.sv
// ============================================================================
// v4cidr_checker
// Port-level checks on the parser's result stream, bound to the top level.
// ============================================================================
`default_nettype none

module v4cidr_checker
    import v4cidr_pkg::*;
(
    input wire logic                   aclk,
    input wire logic                   aresetn,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    // The result stream is empty in the cycle after reset.
    a_empty_after_reset: assert property (
        @(posedge aclk) !aresetn |=> !m_tvalid
    ) else $error("result valid right after reset");

    // A stalled word stays offered.
    a_hold_valid: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid
    ) else $error("result dropped while stalled");

    // Only the defined error codes appear.
    a_err_range: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[42:40] <= ERR_SLASH)
    ) else $error("undefined error code");

    // A failed string reports a zero mask length.
    a_err_mask: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[42:40] != ERR_NONE) |-> (m_tdata[39:32] == '0)
    ) else $error("nonzero mask on an error result");

    // The pad bits above the error code stay zero.
    a_pad_zero: assert property (
        @(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[47:43] == '0)
    ) else $error("pad bits set in result word");

endmodule

bind ipv4_cidr_text_parser v4cidr_checker u_v4cidr_checker (.*);

`default_nettype wire

### tb/sv/ipv4_cidr_text_parser_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// ipv4_cidr_text_parser_tb
// Streams address text one character per word into the parser and checks
// every result word against a cycle-free parse of the same characters.
// Covers a directed set of well-formed and broken strings, random text with
// random gaps on both sides, a stretch at full rate, and a long output stall.
// ============================================================================

module ipv4_cidr_text_parser_tb;
    import v4cidr_pkg::*;

    typedef logic [CHAR_W-1:0] text_t[$];

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [7:0] character
    logic                   s_tlast  = 1'b0; // last character of the string
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;         // [31:0] address, [39:32] mask_length,
                                             // [42:40] error_code, [47:43] zero

    // Parse state, mirrored from the text accepted so far.
    phase_t            cur_phase     = PH_OCTETS;
    logic [CNT_W-1:0]  octets_done   = '0;
    logic [VAL_W-1:0]  run_value     = '0;
    logic              run_has_digit = 1'b0;
    logic [ADDR_W-1:0] addr_acc      = '0;
    err_t              cur_error     = ERR_NONE;

    result_t expected_results[$];
    int      fail_count      = 0;
    bit      full_rate       = 1'b0;
    int      hold_off_cycles = 0;

    ipv4_cidr_text_parser DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Ends the digit run as an octet and places it by position.
    function automatic err_t finish_octet();
        if (!run_has_digit)
            return ERR_NUMBER;
        if (run_value > MAX_OCTET)
            return ERR_RANGE;
        addr_acc |= 32'(run_value[7:0]) << (OCTET_BITS * octets_done[1:0]);
        octets_done   = octets_done + 1'b1;
        run_value     = '0;
        run_has_digit = 1'b0;
        return ERR_NONE;
    endfunction

    function automatic void predict_char(input logic [CHAR_W-1:0] ch, input logic last,
                                         output logic emit, output result_t res);
        logic [MASK_W-1:0] mask;
        err_t              e;
        int                nxt;
        emit = 1'b0;
        res  = '0;
        mask = '0;
        if (cur_error == ERR_NONE) begin
            if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                nxt           = int'(run_value) * 10 + int'(ch) - int'(CHAR_ZERO);
                run_value     = (nxt > int'(VALUE_CAP)) ? VALUE_CAP : VAL_W'(nxt);
                run_has_digit = 1'b1;
            end else if (cur_phase == PH_MASK) begin
                cur_error = ERR_NUMBER;
            end else begin
                e = finish_octet();
                if (e != ERR_NONE)
                    cur_error = e;
                else if (octets_done < OCTETS) begin
                    if (ch != CHAR_DOT)
                        cur_error = ERR_DOT;
                end else if (ch != CHAR_SLASH)
                    cur_error = ERR_SLASH;
                else
                    cur_phase = PH_MASK;
            end
        end
        if (last) begin
            if (cur_error == ERR_NONE) begin
                if (cur_phase == PH_OCTETS) begin
                    e = finish_octet();
                    if (e != ERR_NONE)
                        cur_error = e;
                    else if (octets_done < OCTETS)
                        cur_error = ERR_DOT;
                    else
                        mask = DEFAULT_MASK;
                end else if (!run_has_digit)
                    cur_error = ERR_NUMBER;
                else if (run_value > MAX_OCTET)
                    cur_error = ERR_RANGE;
                else
                    mask = run_value[7:0];
            end
            if (cur_error != ERR_NONE)
                mask = '0;
            emit            = 1'b1;
            res.address     = addr_acc;
            res.mask_length = mask;
            res.error_code  = cur_error;
            cur_phase       = PH_OCTETS;
            octets_done     = '0;
            run_value       = '0;
            run_has_digit   = 1'b0;
            addr_acc        = '0;
            cur_error       = ERR_NONE;
        end
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last);
        int      gap;
        logic    emit;
        result_t res;
        gap = full_rate ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        // Inputs only move at rising edges, so the mid-cycle view decides the transfer.
        do @(negedge aclk); while (s_tready !== 1'b1);
        @(posedge aclk);
        predict_char(ch, last, emit, res);
        if (emit)
            expected_results.insert(expected_results.size(), res);
    endtask

    task automatic send_text(input text_t t);
        foreach (t[i])
            send_char(t[i], i == t.size() - 1);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic text_t to_text(input string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.insert(t.size(), s[i]);
        return t;
    endfunction

    function automatic int pick_value();
        case ($urandom_range(0, 15))
            0:       return 0;
            1:       return 255;
            2:       return $urandom_range(256, 999);
            3:       return $urandom_range(1000, 99999);
            4:       return $urandom_range(0, 32);
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic string decimal_text(input int v);
        string s;
        s = $sformatf("%0d", v);
        if ($urandom_range(0, 7) == 0)
            s = {"0", s};
        return s;
    endfunction

    // Mostly well-formed addresses with random content; the rest is broken
    // addresses and plain noise.
    function automatic text_t random_text();
        text_t t;
        string s;
        int    kind;
        int    pos;
        kind = $urandom_range(0, 19);
        if (kind < 3) begin
            repeat ($urandom_range(1, 8)) t.insert(t.size(), CHAR_W'($urandom_range(0, 255)));
            return t;
        end
        s = decimal_text(pick_value());
        repeat (OCTETS - 1) s = {s, ".", decimal_text(pick_value())};
        if ($urandom_range(0, 2) != 0)
            s = {s, "/", decimal_text(pick_value())};
        t   = to_text(s);
        pos = $urandom_range(0, t.size() - 1);
        case (kind)
            3:       t[pos] = CHAR_W'($urandom_range(0, 255));
            4:       t[pos] = $urandom_range(0, 1) ? CHAR_DOT : CHAR_SLASH;
            5:       t = t[0:pos];
            6:       t.delete(pos);
            default: ;
        endcase
        return t;
    endfunction

    task automatic test_directed();
        send_text(to_text("0.0.0.0"));
        send_text(to_text("255.255.255.255/255"));
        send_text(to_text("1.2.3.4/0"));
        send_text(to_text("10.20.30.40/32"));
        send_text(to_text("007.0.00.9"));
        send_text(to_text(".1.2.3"));
        send_text(to_text("1..2.3"));
        send_text(to_text("256.1.1.1"));
        send_text(to_text("99999.1.1.1"));
        send_text(to_text("1.2.3.256"));
        send_text(to_text("1,2.3.4"));
        send_text(to_text("1.2.3"));
        send_text(to_text("5"));
        send_text(to_text("1.2.3.4a"));
        send_text(to_text("1.2.3.4.5"));
        send_text(to_text("1.2.3.4/"));
        send_text(to_text("1.2.3.4/256"));
        send_text(to_text("1.2.3.4/0099999"));
        send_text(to_text("1.2.3.4/3x"));
        send_text(to_text("1.2.3.4/1/2"));
        send_char(8'hFF, 1'b0);
        send_char(8'h00, 1'b1);
    endtask

    task automatic test_random_text(input int char_budget);
        text_t t;
        int    sent;
        sent = 0;
        while (sent < char_budget) begin
            t = random_text();
            send_text(t);
            sent += t.size();
        end
    endtask

    task automatic test_full_rate();
        full_rate = 1'b1;
        test_random_text(150);
        full_rate = 1'b0;
    endtask

    // The sink stops for a long stretch while text keeps coming, so the
    // result register fills and the input stalls.
    task automatic test_backpressure();
        drain();
        hold_off_cycles = HOLD_CYCLES;
        full_rate       = 1'b1;
        repeat (16) send_text(random_text());
        full_rate = 1'b0;
    endtask

    // Result sink: random stalls per word, or one long hold when requested.
    initial begin
        int stall;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge aclk);
                hold_off_cycles = 0;
            end else begin
                stall = full_rate ? 0 : $urandom_range(0, 4);
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            do @(negedge aclk); while (m_tvalid !== 1'b1);
            @(posedge aclk);
        end
    end

    always @(negedge aclk) begin
        result_t got;
        result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready === 1'b1) begin
            got = m_tdata[$bits(result_t)-1:0];
            if (expected_results.size() == 0) begin
                $error("unexpected result word: %h", m_tdata);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.address !== want.address) begin
                    $error("address: expected %h, actual %h", want.address, got.address);
                    fail_count++;
                end
                if (got.mask_length !== want.mask_length) begin
                    $error("mask_length: expected %0d, actual %0d",
                           want.mask_length, got.mask_length);
                    fail_count++;
                end
                if (got.error_code !== want.error_code) begin
                    $error("error_code: expected %0d, actual %0d",
                           want.error_code, got.error_code);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random_text(700);
        test_full_rate();
        test_backpressure();
        drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
